FILE: src/odo_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and tables of the three-wheel odometry integrator.
// Used by the channel interfaces and every module of the block.
package odo_pkg;

    // Field widths
    localparam int ANG_W     = 32;
    localparam int POS_W     = 32;
    localparam int HDG_W     = 19;
    localparam int Q_W       = 16;
    localparam int A2D_W     = 16;
    localparam int SPAN_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;
    localparam int SUM_W     = ANG_W + 1;

    // Bit-serial multiplier: signed multiplicand, signed multiplier scanned LSB first
    localparam int MA_W      = 36;
    localparam int MB_W      = 33;
    localparam int MP_W      = MA_W + 1 + MB_W;
    localparam int MUL_STEPS = MB_W;
    localparam int MCNT_W    = $clog2(MUL_STEPS);

    // CORDIC rotation on the half angle, Q2.30
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_N       = 24;
    localparam int CI_W         = $clog2(ATAN_N);
    localparam int CR_W         = 34;
    localparam int TRIG_W       = 33;
    localparam int CORDIC_GAIN  = 652032874;

    localparam logic [29:0] ATAN_Q30 [ATAN_N] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536,
        30'd32768, 30'd16384, 30'd8192, 30'd4096, 30'd2048,
        30'd1024, 30'd512, 30'd256, 30'd128
    };

    // Heading wrap: bias the sum positive by whole turns, then shift-subtract
    localparam int HALF_TURN  = 205888;
    localparam int FULL_TURN  = 411775;
    localparam int WRAP_W     = 34;
    localparam int WRAP_STEPS = 15;
    localparam int WCNT_W     = $clog2(WRAP_STEPS);
    localparam logic [WRAP_W-1:0] WRAP_OFS =
        WRAP_W'(longint'(10431) * longint'(FULL_TURN) + longint'(HALF_TURN));
    localparam logic [WRAP_W-1:0] WRAP_TOP =
        WRAP_W'(longint'(FULL_TURN) << (WRAP_STEPS - 1));

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A2D  = 2'd0,
        CFG_SPAN = 2'd1,
        CFG_LOFS = 2'd2
    } t_cfg_idx;

endpackage

FILE: src/odo_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: encoder sample, pose result, register write.
// Depends on odo_pkg for field widths.
interface odo_in_if;
    import odo_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] left_angle;
    logic signed [ANG_W-1:0] right_angle;
    logic signed [ANG_W-1:0] front_angle;
    modport source(output valid, left_angle, right_angle, front_angle, input ready);
    modport sink(input valid, left_angle, right_angle, front_angle, output ready);
endinterface

interface odo_out_if;
    import odo_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [HDG_W-1:0] heading;
    logic signed [Q_W-1:0]   orient_z;
    logic signed [Q_W-1:0]   orient_w;
    modport source(output valid, pos_x, pos_y, heading, orient_z, orient_w, input ready);
    modport sink(input valid, pos_x, pos_y, heading, orient_z, orient_w, output ready);
endinterface

interface odo_cfg_if;
    import odo_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

FILE: src/odo_smul.sv
`timescale 1ns / 1ps
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
// Depends on odo_pkg for operand widths.
module odo_smul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  logic signed [odo_pkg::MA_W-1:0] i_a,
    input  logic signed [odo_pkg::MB_W-1:0] i_b,
    output logic                           o_busy,
    output logic                           o_done,
    output logic signed [odo_pkg::MP_W-1:0] o_p
);
    import odo_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [MCNT_W-1:0]       r_cnt;
    logic signed [MA_W-1:0]  r_a;
    logic signed [MA_W:0]    r_hi;
    logic [MB_W-1:0]         r_lo;
    logic                    last;
    logic signed [MA_W:0]    addend;
    logic signed [MA_W:0]    sum;

    // The multiplier sign bit carries negative weight
    assign last = (r_cnt == MCNT_W'(MUL_STEPS - 1));

    always_comb begin
        if (!r_lo[0]) begin
            addend = '0;
        end else if (last) begin
            addend = -((MA_W + 1)'(r_a));
        end else begin
            addend = (MA_W + 1)'(r_a);
        end
        sum = r_hi + addend;
    end

    // Load, then add and shift one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_hi   <= '0;
                r_lo   <= i_b;
            end else if (r_busy) begin
                r_hi  <= {sum[MA_W], sum[MA_W:1]};
                r_lo  <= {sum[0], r_lo[MB_W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_p    = $signed({r_hi, r_lo});

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |-> !r_busy) else $error("multiplier started while busy");
    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("multiplier done without a run");

endmodule

FILE: src/odo_cordic.sv
`timescale 1ns / 1ps
// Iterative CORDIC rotation: half-angle sine and cosine of a Q3.16 heading.
// Depends on odo_pkg for the arctangent table and step count.
module odo_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  logic signed [odo_pkg::HDG_W-1:0]  i_angle,
    output logic                              o_done,
    output logic signed [odo_pkg::TRIG_W-1:0] o_sin,
    output logic signed [odo_pkg::TRIG_W-1:0] o_cos
);
    import odo_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [CI_W-1:0]        r_i;
    logic signed [CR_W-1:0] r_x;
    logic signed [CR_W-1:0] r_y;
    logic signed [CR_W-1:0] r_z;
    logic signed [CR_W-1:0] xs;
    logic signed [CR_W-1:0] ys;
    logic signed [CR_W-1:0] at;
    logic                   last;

    assign xs   = r_x >>> r_i;
    assign ys   = r_y >>> r_i;
    assign at   = $signed({{(CR_W - 30){1'b0}}, ATAN_Q30[r_i]});
    assign last = (r_i == CI_W'(CORDIC_STEPS - 1));

    // Rotate toward zero residual angle, one micro-rotation per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= CR_W'(CORDIC_GAIN);
                r_y    <= '0;
                r_z    <= CR_W'(i_angle) <<< 13;
            end else if (r_busy) begin
                if (!r_z[CR_W-1]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                r_i <= r_i + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_y[TRIG_W-1:0];
    assign o_cos  = r_x[TRIG_W-1:0];

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && last && !i_go) |=> r_done) else $error("CORDIC did not finish");

endmodule

FILE: src/odo_hwrap.sv
`timescale 1ns / 1ps
// Serial heading wrap into one turn: biased shift-subtract, one bit per cycle.
// Depends on odo_pkg for turn constants.
module odo_hwrap (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_go,
    input  logic signed [odo_pkg::SUM_W-1:0] i_sum,
    output logic                             o_done,
    output logic signed [odo_pkg::HDG_W-1:0] o_heading
);
    import odo_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [WCNT_W-1:0]  r_k;
    logic [WRAP_W-1:0]  r_r;
    logic [WRAP_W-1:0]  r_d;
    logic               last;

    assign last = (r_k == WCNT_W'(WRAP_STEPS - 1));

    // Subtract the shifted turn where it fits, then halve it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_r    <= WRAP_W'(i_sum) + WRAP_OFS;
                r_d    <= WRAP_TOP;
            end else if (r_busy) begin
                if (r_r >= r_d) begin
                    r_r <= r_r - r_d;
                end
                r_d <= r_d >> 1;
                r_k <= r_k + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_heading = $signed(r_r[HDG_W-1:0] - HDG_W'(HALF_TURN));

    a_in_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (int'(o_heading) >= -HALF_TURN && int'(o_heading) < HALF_TURN))
        else $error("wrapped heading outside one turn");

endmodule

FILE: src/three_wheel_odometry_integrator.sv
`timescale 1ns / 1ps
// Top level of the three-wheel odometry integrator: sequencer, state and ports.
// Depends on odo_pkg, odo_if, odo_smul, odo_cordic and odo_hwrap.

// Each accepted sample of left, right and front encoder angles yields one pose
// result (x, y, wrapped heading, yaw quaternion z and w). The work of a sample
// is dominated by twelve passes through the one shared bit-serial multiplier,
// plus two CORDIC runs, a heading wrap and the load of the output register.
// One sample is in work at a time; a finished result waits in the output
// register while the next sample is taken. Register writes take effect at
// once and belong between samples.
module three_wheel_odometry_integrator (
    input  logic     i_clk,
    input  logic     i_rst_n,
    odo_in_if.sink   i_sample,
    odo_out_if.source o_result,
    odo_cfg_if.sink  i_cfg
);
    import odo_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_COR1, ST_WRAP, ST_COR2, ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_SL, OP_SR, OP_SF, OP_ROT, OP_LAT, OP_SC,
        OP_CC, OP_SS, OP_FC, OP_LS, OP_FS, OP_LC
    } t_op;

    t_state r_state;
    t_op    r_op;
    logic   r_mul_go;
    logic   r_cor_go;
    logic   r_wrap_go;

    // Configuration
    logic [A2D_W-1:0]  r_a2d;
    logic [SPAN_W-1:0] r_span;
    logic [SPAN_W-1:0] r_lofs;

    // Pose state
    logic signed [ANG_W-1:0] r_prev_l, r_prev_r, r_prev_f;
    logic signed [POS_W-1:0] r_acc_x, r_acc_y;
    logic signed [HDG_W-1:0] r_acc_h;

    // Work registers
    logic signed [ANG_W-1:0]  r_ang_l, r_ang_r, r_ang_f;
    logic signed [ANG_W-1:0]  r_left, r_right, r_front;
    logic signed [SUM_W-1:0]  r_dl, r_dr, r_df;
    logic signed [ANG_W-1:0]  r_fwd, r_rot, r_lat;
    logic signed [TRIG_W-1:0] r_s, r_c, r_sh, r_ch;
    logic signed [MP_W-1:0]   r_t;
    logic signed [POS_W-1:0]  r_ax, r_ay;
    logic signed [HDG_W-1:0]  r_hn;

    // Output register
    logic                    r_ov;
    logic signed [POS_W-1:0] r_ox, r_oy;
    logic signed [HDG_W-1:0] r_oh;
    logic signed [Q_W-1:0]   r_oz, r_ow;

    // Unit connections
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic                     mul_busy, mul_done;
    logic signed [MP_W-1:0]   mul_p;
    logic signed [HDG_W-1:0]  cor_angle;
    logic                     cor_done;
    logic signed [TRIG_W-1:0] cor_sin, cor_cos;
    logic signed [SUM_W-1:0]  wrap_sum;
    logic                     wrap_done;
    logic signed [HDG_W-1:0]  wrap_hdg;

    // Post-processing values
    logic signed [ANG_W-1:0] scl;
    logic signed [ANG_W-1:0] nscl;
    logic signed [MP_W-1:0]  p16;
    logic signed [MP_W-1:0]  diff;
    logic signed [MP_W-1:0]  dsum;
    logic                    out_free;

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [MP_W-1:0] v);
        logic fits;
        fits = (&v[MP_W-1:POS_W-1]) || !(|v[MP_W-1:POS_W-1]);
        if (fits) begin
            sat32 = v[POS_W-1:0];
        end else if (v[MP_W-1]) begin
            sat32 = {1'b1, {(POS_W - 1){1'b0}}};
        end else begin
            sat32 = {1'b0, {(POS_W - 1){1'b1}}};
        end
    endfunction

    function automatic logic signed [Q_W-1:0] to_q15(input logic signed [TRIG_W-1:0] v);
        logic signed [TRIG_W:0] r;
        r = (TRIG_W + 1)'(v) + (TRIG_W + 1)'(16384);
        r = r >>> 15;
        if (r > (TRIG_W + 1)'(32767)) begin
            to_q15 = 16'sh7fff;
        end else if (r < -(TRIG_W + 1)'(32768)) begin
            to_q15 = 16'sh8000;
        end else begin
            to_q15 = r[Q_W-1:0];
        end
    endfunction

    // Select multiplier operands for the current step
    always_comb begin
        unique case (r_op)
            OP_SL:   begin mul_a = MA_W'(r_ang_l); mul_b = MB_W'(r_a2d); end
            OP_SR:   begin mul_a = MA_W'(r_ang_r); mul_b = MB_W'(r_a2d); end
            OP_SF:   begin mul_a = MA_W'(r_ang_f); mul_b = MB_W'(r_a2d); end
            OP_ROT:  begin mul_a = MA_W'(r_dl) - MA_W'(r_dr); mul_b = MB_W'(r_span); end
            OP_LAT:  begin mul_a = MA_W'(r_rot); mul_b = MB_W'(r_lofs); end
            OP_SC:   begin mul_a = MA_W'(r_s); mul_b = MB_W'(r_c); end
            OP_CC:   begin mul_a = MA_W'(r_c); mul_b = MB_W'(r_c); end
            OP_SS:   begin mul_a = MA_W'(r_s); mul_b = MB_W'(r_s); end
            OP_FC:   begin mul_a = MA_W'(r_fwd); mul_b = r_ch; end
            OP_LS:   begin mul_a = MA_W'(r_lat); mul_b = r_sh; end
            OP_FS:   begin mul_a = MA_W'(r_fwd); mul_b = r_sh; end
            OP_LC:   begin mul_a = MA_W'(r_lat); mul_b = r_ch; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign scl       = mul_p[ANG_W+15:16];
    assign nscl      = -scl;
    assign p16       = mul_p >>> 16;
    assign diff      = (r_t - mul_p) >>> 30;
    assign dsum      = (r_t + mul_p) >>> 30;
    assign cor_angle = (r_state == ST_COR1) ? r_acc_h : r_hn;
    assign wrap_sum  = SUM_W'(r_acc_h) + SUM_W'(r_rot);
    assign out_free  = !r_ov || o_result.ready;

    odo_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    odo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_cor_go),
        .i_angle (cor_angle),
        .o_done  (cor_done),
        .o_sin   (cor_sin),
        .o_cos   (cor_cos)
    );

    odo_hwrap u_hwrap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (r_wrap_go),
        .i_sum     (wrap_sum),
        .o_done    (wrap_done),
        .o_heading (wrap_hdg)
    );

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a2d  <= A2D_W'(6554);
            r_span <= SPAN_W'(81920);
            r_lofs <= SPAN_W'(26214);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_A2D:  r_a2d  <= i_cfg.data[A2D_W-1:0];
                CFG_SPAN: r_span <= i_cfg.data[SPAN_W-1:0];
                CFG_LOFS: r_lofs <= i_cfg.data[SPAN_W-1:0];
                default:  ;
            endcase
        end
    end

    // Sequencer, pose state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_op      <= OP_SL;
            r_mul_go  <= 1'b0;
            r_cor_go  <= 1'b0;
            r_wrap_go <= 1'b0;
            r_ov      <= 1'b0;
            r_prev_l  <= '0;
            r_prev_r  <= '0;
            r_prev_f  <= '0;
            r_acc_x   <= '0;
            r_acc_y   <= '0;
            r_acc_h   <= '0;
        end else begin
            r_mul_go  <= 1'b0;
            r_cor_go  <= 1'b0;
            r_wrap_go <= 1'b0;
            // Load a finished pose, hold an untaken one, drop a taken one
            r_ov <= ((r_state == ST_DONE) && out_free) || (r_ov && !o_result.ready);
            unique case (r_state)
                ST_IDLE: begin
                    if (i_sample.valid) begin
                        r_ang_l  <= i_sample.left_angle;
                        r_ang_r  <= i_sample.right_angle;
                        r_ang_f  <= i_sample.front_angle;
                        r_op     <= OP_SL;
                        r_mul_go <= 1'b1;
                        r_state  <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        r_mul_go <= 1'b1;
                        unique case (r_op)
                            OP_SL: begin
                                r_left <= nscl;
                                r_dl   <= SUM_W'(nscl) - SUM_W'(r_prev_l);
                                r_op   <= OP_SR;
                            end
                            OP_SR: begin
                                r_right <= scl;
                                r_dr    <= SUM_W'(scl) - SUM_W'(r_prev_r);
                                r_op    <= OP_SF;
                            end
                            OP_SF: begin
                                r_front <= nscl;
                                r_df    <= SUM_W'(nscl) - SUM_W'(r_prev_f);
                                r_fwd   <= sat32((MP_W'(r_dl) + MP_W'(r_dr)) >>> 1);
                                r_op    <= OP_ROT;
                            end
                            OP_ROT: begin
                                r_rot <= sat32(p16);
                                r_op  <= OP_LAT;
                            end
                            OP_LAT: begin
                                r_lat    <= sat32(MP_W'(r_df) - p16);
                                r_mul_go <= 1'b0;
                                r_cor_go <= 1'b1;
                                r_state  <= ST_COR1;
                            end
                            OP_SC: begin
                                r_sh <= mul_p[TRIG_W+28:29];
                                r_op <= OP_CC;
                            end
                            OP_CC: begin
                                r_t  <= mul_p;
                                r_op <= OP_SS;
                            end
                            OP_SS: begin
                                r_ch <= diff[TRIG_W-1:0];
                                r_op <= OP_FC;
                            end
                            OP_FC: begin
                                r_t  <= mul_p;
                                r_op <= OP_LS;
                            end
                            OP_LS: begin
                                r_ax <= sat32(MP_W'(r_acc_x) + diff);
                                r_op <= OP_FS;
                            end
                            OP_FS: begin
                                r_t  <= mul_p;
                                r_op <= OP_LC;
                            end
                            OP_LC: begin
                                r_ay      <= sat32(MP_W'(r_acc_y) + dsum);
                                r_mul_go  <= 1'b0;
                                r_wrap_go <= 1'b1;
                                r_state   <= ST_WRAP;
                            end
                            default: begin
                                r_mul_go <= 1'b0;
                                r_state  <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_COR1: begin
                    if (cor_done) begin
                        r_s      <= cor_sin;
                        r_c      <= cor_cos;
                        r_op     <= OP_SC;
                        r_mul_go <= 1'b1;
                        r_state  <= ST_MUL;
                    end
                end
                ST_WRAP: begin
                    if (wrap_done) begin
                        r_hn     <= wrap_hdg;
                        r_cor_go <= 1'b1;
                        r_state  <= ST_COR2;
                    end
                end
                ST_COR2: begin
                    if (cor_done) begin
                        r_s     <= cor_sin;
                        r_c     <= cor_cos;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Hold until the output register is free, then commit the pose
                    if (out_free) begin
                        r_ox     <= r_ax;
                        r_oy     <= r_ay;
                        r_oh     <= r_hn;
                        r_oz     <= to_q15(r_s);
                        r_ow     <= to_q15(r_c);
                        r_prev_l <= r_left;
                        r_prev_r <= r_right;
                        r_prev_f <= r_front;
                        r_acc_x  <= r_ax;
                        r_acc_y  <= r_ay;
                        r_acc_h  <= r_hn;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_sample.ready   = (r_state == ST_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_result.valid   = r_ov;
    assign o_result.pos_x   = r_ox;
    assign o_result.pos_y   = r_oy;
    assign o_result.heading = r_oh;
    assign o_result.orient_z = r_oz;
    assign o_result.orient_w = r_ow;

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == ST_DONE)) else $error("result without a finished sample");
    a_idle_units_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mul_busy) else $error("multiplier busy while idle");

endmodule
